// ===== sv/t8cpu_pkg.sv =====
// ----------------------------------------------------------------------------
// t8cpu_pkg
// Types and constants shared by the toy 8-bit CPU step block: the opcode set,
// the item mode codes, the incoming item and the reported machine state.
// ----------------------------------------------------------------------------
package t8cpu_pkg;

    // Item mode carried in the input tuser bit.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EXEC = 1'b1;

    // Widths of the machine.
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned MEM_D   = 16;
    localparam int unsigned NREG    = 4;
    localparam int unsigned RSEL_W  = 2;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 40;

    // Instruction opcodes held in the upper nibble of an instruction byte.
    typedef enum logic [3:0] {
        OP_INC = 4'h0,
        OP_DEC = 4'h1,
        OP_ADD = 4'h2,
        OP_SUB = 4'h3,
        OP_LD0 = 4'h4,
        OP_LD1 = 4'h5,
        OP_LD2 = 4'h6,
        OP_LD3 = 4'h7,
        OP_ST0 = 4'h8,
        OP_ST1 = 4'h9,
        OP_ST2 = 4'hA,
        OP_ST3 = 4'hB,
        OP_JMP = 4'hC,
        OP_JZ  = 4'hD,
        OP_JC  = 4'hE,
        OP_HLT = 4'hF
    } t_opcode;

    // One input item as held in the input register.
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] load_addr;
        logic [DATA_W-1:0] load_data;
    } t_in_item;

    // Machine state reported after each item.
    typedef struct packed {
        logic              halted;
        logic              carry_flag;
        logic              zero_flag;
        logic [DATA_W-1:0] reg_d;
        logic [DATA_W-1:0] reg_c;
        logic [DATA_W-1:0] reg_b;
        logic [DATA_W-1:0] reg_a;
        logic [ADDR_W-1:0] pc_value;
    } t_result;

endpackage

// ===== sv/t8cpu_in_stage.sv =====
// ----------------------------------------------------------------------------
// t8cpu_in_stage
// Input register: holds one accepted beat until the core consumes it, and
// accepts a new beat in the same cycle the held one is taken.
// ----------------------------------------------------------------------------
module t8cpu_in_stage
    import t8cpu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_in_item o_item,
    input  logic     i_take
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    // Free when empty, or when the held beat leaves this cycle.
    assign o_ready = !r_valid || i_take;

    always_comb begin
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/t8cpu_core.sv =====
// ----------------------------------------------------------------------------
// t8cpu_core
// Machine state and the combinational fetch, decode and execute of one item.
// The state after the item is presented combinationally for the result
// register and committed on the same edge.
// ----------------------------------------------------------------------------
module t8cpu_core
    import t8cpu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_go,
    input  t_in_item i_item,
    output t_result  o_res
);

    logic [DATA_W-1:0] r_mem  [MEM_D];
    logic [DATA_W-1:0] r_regs [NREG];
    logic [DATA_W-1:0] n_regs [NREG];
    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] n_pc;
    logic              r_zero;
    logic              n_zero;
    logic              r_carry;
    logic              n_carry;
    logic              r_halt;
    logic              n_halt;

    logic [DATA_W-1:0] ins;
    t_opcode           opc;
    logic [ADDR_W-1:0] addr;
    logic [RSEL_W-1:0] r1;
    logic [RSEL_W-1:0] r2;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W:0]   alu;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [DATA_W-1:0] mem_wd;
    logic              exec;

    // Fetch and decode at the current program counter.
    assign ins  = r_mem[r_pc];
    assign opc  = t_opcode'(ins[7:4]);
    assign addr = ins[3:0];
    assign r1   = ins[3:2];
    assign r2   = ins[1:0];
    assign opb  = r_regs[r2];
    assign opa  = r_regs[r1];
    assign exec = i_go && (i_item.mode == MODE_EXEC) && !r_halt;

    // Shared 9-bit adder; bit 8 is the carry out or the borrow.
    always_comb begin
        case (opc)
            OP_INC:  alu = {1'b0, opa} + {1'b0, 8'd1};
            OP_DEC:  alu = {1'b0, opa} - {1'b0, 8'd1};
            OP_ADD:  alu = {1'b0, opa} + {1'b0, opb};
            OP_SUB:  alu = {1'b0, opa} - {1'b0, opb};
            default: alu = {1'b0, opa};
        endcase
    end

    // Next machine state.
    always_comb begin
        for (int i = 0; i < NREG; i++) begin
            n_regs[i] = r_regs[i];
        end
        n_pc    = r_pc;
        n_zero  = r_zero;
        n_carry = r_carry;
        n_halt  = r_halt;
        mem_we  = 1'b0;
        mem_wa  = i_item.load_addr;
        mem_wd  = i_item.load_data;
        if (i_go && (i_item.mode == MODE_LOAD)) begin
            mem_we = 1'b1;
        end else if (exec) begin
            n_pc = r_pc + 4'd1;
            case (opc)
                OP_INC, OP_DEC, OP_ADD, OP_SUB: begin
                    n_regs[r1] = alu[DATA_W-1:0];
                    n_zero     = (alu[DATA_W-1:0] == '0);
                    n_carry    = alu[DATA_W];
                end
                OP_LD0, OP_LD1, OP_LD2, OP_LD3: begin
                    n_regs[ins[5:4]] = r_mem[addr];
                end
                OP_ST0, OP_ST1, OP_ST2, OP_ST3: begin
                    mem_we = 1'b1;
                    mem_wa = addr;
                    mem_wd = r_regs[ins[5:4]];
                end
                OP_JMP: begin
                    n_pc = addr;
                end
                OP_JZ: begin
                    if (r_zero) begin
                        n_pc = addr;
                    end
                end
                OP_JC: begin
                    if (r_carry) begin
                        n_pc = addr;
                    end
                end
                OP_HLT: begin
                    n_halt = 1'b1;
                end
                default: begin
                    n_halt = r_halt;
                end
            endcase
        end
    end

    // Architectural state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_zero  <= 1'b0;
            r_carry <= 1'b0;
            r_halt  <= 1'b0;
            for (int i = 0; i < NREG; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            r_pc    <= n_pc;
            r_zero  <= n_zero;
            r_carry <= n_carry;
            r_halt  <= n_halt;
            for (int i = 0; i < NREG; i++) begin
                r_regs[i] <= n_regs[i];
            end
        end
    end

    // Sixteen-byte memory, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_D; i++) begin
                r_mem[i] <= '0;
            end
        end else if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    // Report the state as it stands after this item.
    always_comb begin
        o_res.pc_value   = n_pc;
        o_res.reg_a      = n_regs[0];
        o_res.reg_b      = n_regs[1];
        o_res.reg_c      = n_regs[2];
        o_res.reg_d      = n_regs[3];
        o_res.zero_flag  = n_zero;
        o_res.carry_flag = n_carry;
        o_res.halted     = n_halt;
    end

    // Only reset may clear the halt.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt bit cleared without reset");

    // A memory load leaves the program counter and flags alone.
    a_load_keeps_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && (i_item.mode == MODE_LOAD)) |=>
            ($stable(r_pc) && $stable(r_zero) && $stable(r_carry)))
        else $error("load item changed pc or flags");

    // A halted machine does not move its program counter.
    a_halted_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt && i_go) |=> $stable(r_pc))
        else $error("pc moved while halted");

    // The state only changes when an item is consumed.
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_go |=> ($stable(r_pc) && $stable(r_halt) && $stable(r_zero)))
        else $error("state changed without an item");

endmodule

// ===== sv/tiny_8bit_cpu_step.sv =====
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_step
// Toy 8-bit CPU stepped one beat at a time: each input beat either writes
// one memory byte or executes one instruction, and each yields one result
// beat with the registers, flags, program counter and halt bit.
//
//  Channel  | Direction | Content
//  ---------+-----------+----------------------------------------------------
//  s (in)   | input     | tuser: mode; tdata: load_addr, load_data
//  m (out)  | output    | tdata: pc, reg_a..reg_d, zero, carry, halted
//
// One beat per cycle is sustained while the output is ready: an input register
// feeds a combinational fetch, decode and execute over a flip-flop register
// file and memory, and the result lands in an output register. Reset
// (synchronous, active low) clears the register file, memory, flags, pc, halt
// bit and both valid bits; the held beat and result payload are not reset. A
// stalled output holds the core; the input register still takes one beat
// while waiting.
// ----------------------------------------------------------------------------
module tiny_8bit_cpu_step
    import t8cpu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] mode
    input  logic                   s_axis_tuser,
    // [3:0] load_addr, [11:4] load_data, [15:12] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [3:0] pc_value, [11:4] reg_a, [19:12] reg_b, [27:20] reg_c,
    // [35:28] reg_d, [36] zero_flag, [37] carry_flag, [38] halted, [39] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_in_item in_item;
    t_in_item held_item;
    logic     held_valid;
    logic     take;
    t_result  res;
    t_result  r_res;
    logic     r_out_valid;

    assign in_item.mode      = s_axis_tuser;
    assign in_item.load_addr = s_axis_tdata[3:0];
    assign in_item.load_data = s_axis_tdata[11:4];

    // Input register.
    t8cpu_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (take)
    );

    // The core steps when a beat is held and the result register can take its beat.
    assign take = held_valid && (!r_out_valid || m_axis_tready);

    t8cpu_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (take),
        .i_item  (held_item),
        .o_res   (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_res};

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the toy 8-bit CPU step block. Programs are loaded
// byte by byte and stepped through; a behavioural copy of the machine state
// predicts the reported registers, flags, pc and halt bit for every beat,
// and each result beat is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    import t8cpu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_LEN   = 370;
    localparam int unsigned RANDOM_END  = 1070;
    localparam int unsigned HOLD_AT     = 800;
    localparam int unsigned HOLD_CYCLES = 150;

    // Complete architectural state of the machine.
    typedef struct packed {
        logic [NREG-1:0][DATA_W-1:0]  regs;
        logic [MEM_D-1:0][DATA_W-1:0] mem;
        logic [ADDR_W-1:0]            pc;
        logic                         zf;
        logic                         cf;
        logic                         halted;
    } t_machine;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [0] mode
    logic                   s_axis_tuser  = 1'b0;
    // [3:0] load_addr, [11:4] load_data, [15:12] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [3:0] pc_value, [11:4] reg_a, [19:12] reg_b, [27:20] reg_c,
    // [35:28] reg_d, [36] zero_flag, [37] carry_flag, [38] halted, [39] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_in_item    pending_beats[$];
    t_result     states_due[$];
    t_machine    cpu_model = '0;
    t_machine    plan_model = '0;
    t_result     state_next;
    t_result     state_seen;
    t_result     state_want;
    bit          halt_allowed = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned beats_in = 0;
    int unsigned beats_out = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    tiny_8bit_cpu_step uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // One step of the machine: a memory write or a fetch and execute.
    function automatic t_machine cpu_execute(input t_machine m, input t_in_item beat);
        t_machine    n;
        logic [7:0]  ins;
        logic [7:0]  lhs;
        logic [7:0]  rhs;
        logic [8:0]  wide;
        logic [1:0]  ra;
        t_opcode     opc;
        n = m;
        if (beat.mode == MODE_LOAD) begin
            n.mem[beat.load_addr] = beat.load_data;
        end else if (!m.halted) begin
            ins = m.mem[m.pc];
            opc = t_opcode'(ins[7:4]);
            ra  = ins[3:2];
            lhs = m.regs[ra];
            // The pc moves on before the instruction takes effect.
            n.pc = m.pc + 4'd1;
            case (opc)
                OP_INC, OP_DEC, OP_ADD, OP_SUB: begin
                    rhs = (opc == OP_INC || opc == OP_DEC) ? 8'd1 : m.regs[ins[1:0]];
                    if (opc == OP_INC || opc == OP_ADD) begin
                        wide = {1'b0, lhs} + {1'b0, rhs};
                    end else begin
                        // Bit 8 of the nine-bit difference is the borrow.
                        wide = {1'b0, lhs} - {1'b0, rhs};
                    end
                    n.regs[ra] = wide[7:0];
                    n.zf = (wide[7:0] == 8'd0);
                    n.cf = wide[8];
                end
                OP_LD0, OP_LD1, OP_LD2, OP_LD3: begin
                    n.regs[ins[5:4]] = m.mem[ins[3:0]];
                end
                OP_ST0, OP_ST1, OP_ST2, OP_ST3: begin
                    n.mem[ins[3:0]] = m.regs[ins[5:4]];
                end
                OP_JMP: begin
                    n.pc = ins[3:0];
                end
                OP_JZ: begin
                    if (m.zf) n.pc = ins[3:0];
                end
                OP_JC: begin
                    if (m.cf) n.pc = ins[3:0];
                end
                default: begin
                    n.halted = 1'b1;
                end
            endcase
        end
        return n;
    endfunction

    function automatic int unsigned sender_idle_pct(input int unsigned n);
        if (n < PHASE_LEN) return 33;
        if (n < 2 * PHASE_LEN) return 64;
        return 0;
    endfunction

    function automatic int unsigned receiver_idle_pct(input int unsigned n);
        if (n < PHASE_LEN) return 64;
        if (n < 2 * PHASE_LEN) return 33;
        return 0;
    endfunction

    // Queue a beat and keep the planning copy of the machine in step with it.
    task automatic queue_beat(input logic mode, input logic [3:0] addr, input logic [7:0] data);
        t_in_item beat;
        beat.mode = mode;
        beat.load_addr = addr;
        beat.load_data = data;
        plan_model = cpu_execute(plan_model, beat);
        pending_beats.push_back(beat);
    endtask

    function automatic logic [7:0] random_instruction();
        return {4'($urandom_range(OP_INC, OP_JC)), 4'($urandom)};
    endfunction

    // Queue an execute beat; a halt about to be fetched too early is patched
    // out first, since only a reset would clear it again.
    task automatic queue_exec();
        if (!halt_allowed && plan_model.mem[plan_model.pc][7:4] == OP_HLT) begin
            queue_beat(MODE_LOAD, plan_model.pc, random_instruction());
        end
        queue_beat(MODE_EXEC, 4'($urandom), 8'($urandom));
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fail_count++;
        end
    endtask

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Input driver: offers the oldest pending beat and predicts on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                cpu_model = cpu_execute(cpu_model, pending_beats.pop_front());
                state_next.pc_value   = cpu_model.pc;
                state_next.reg_a      = cpu_model.regs[0];
                state_next.reg_b      = cpu_model.regs[1];
                state_next.reg_c      = cpu_model.regs[2];
                state_next.reg_d      = cpu_model.regs[3];
                state_next.zero_flag  = cpu_model.zf;
                state_next.carry_flag = cpu_model.cf;
                state_next.halted     = cpu_model.halted;
                states_due.push_back(state_next);
                beats_in++;
            end
            if (pending_beats.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct(beats_in)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_beats[0].mode;
                s_axis_tdata  <= {4'b0000, pending_beats[0].load_data,
                                  pending_beats[0].load_addr};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: compares each result beat and paces tready, with one
    // long hold-off so that the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                state_seen = m_axis_tdata[$bits(t_result)-1:0];
                if (states_due.size() == 0) begin
                    $error("result beat with no expected state waiting");
                    fail_count++;
                end else begin
                    state_want = states_due.pop_front();
                    check_field("pc_value", 8'(state_want.pc_value), 8'(state_seen.pc_value));
                    check_field("reg_a", state_want.reg_a, state_seen.reg_a);
                    check_field("reg_b", state_want.reg_b, state_seen.reg_b);
                    check_field("reg_c", state_want.reg_c, state_seen.reg_c);
                    check_field("reg_d", state_want.reg_d, state_seen.reg_d);
                    check_field("zero_flag", 8'(state_want.zero_flag),
                                8'(state_seen.zero_flag));
                    check_field("carry_flag", 8'(state_want.carry_flag),
                                8'(state_seen.carry_flag));
                    check_field("halted", 8'(state_want.halted), 8'(state_seen.halted));
                end
                beats_out++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && beats_out >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct(beats_out));
            end
        end
    end

    // Stimulus, then the end of the run.
    initial begin
        int unsigned n_exec;

        // Directed program: load from the top byte, increment and decrement
        // through the wrap points, add and subtract with carry and borrow,
        // a store read back later, a taken and an untaken JC, a taken JZ and a JMP.
        queue_beat(MODE_LOAD, 4'd15, 8'hFF);
        queue_beat(MODE_LOAD, 4'd0,  {OP_LD0, 4'hF});
        queue_beat(MODE_LOAD, 4'd1,  {OP_INC, 4'h0});
        queue_beat(MODE_LOAD, 4'd2,  {OP_DEC, 4'h4});
        queue_beat(MODE_LOAD, 4'd3,  {OP_ADD, 4'h5});
        queue_beat(MODE_LOAD, 4'd4,  {OP_SUB, 4'h9});
        queue_beat(MODE_LOAD, 4'd5,  {OP_ST1, 4'hE});
        queue_beat(MODE_LOAD, 4'd6,  {OP_JC,  4'h8});
        queue_beat(MODE_LOAD, 4'd8,  {OP_SUB, 4'hF});
        queue_beat(MODE_LOAD, 4'd9,  {OP_JZ,  4'hB});
        queue_beat(MODE_LOAD, 4'd11, {OP_JC,  4'h0});
        queue_beat(MODE_LOAD, 4'd12, {OP_JMP, 4'hD});
        queue_beat(MODE_LOAD, 4'd13, {OP_LD3, 4'hE});
        repeat (12) queue_exec();

        // Random programs with random content, stepped for a while, with
        // stray memory writes landing in the middle of execution.
        while (pending_beats.size() < RANDOM_END) begin
            for (int a = 0; a < MEM_D; a++) begin
                if ($urandom_range(0, 3) != 0) begin
                    queue_beat(MODE_LOAD, 4'(a),
                               ($urandom_range(0, 2) == 0) ? 8'($urandom) : random_instruction());
                end
            end
            n_exec = $urandom_range(8, 40);
            for (int k = 0; k < n_exec; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    queue_beat(MODE_LOAD, 4'($urandom), 8'($urandom));
                end
                queue_exec();
            end
        end

        // Halt at the top address so the pc wraps, then steps and memory
        // writes while halted.
        halt_allowed = 1'b1;
        queue_beat(MODE_LOAD, plan_model.pc, {OP_JMP, 4'hF});
        queue_beat(MODE_LOAD, 4'd15, {OP_HLT, 4'($urandom)});
        queue_exec();
        queue_exec();
        repeat (4) queue_exec();
        queue_beat(MODE_LOAD, 4'd0, {OP_INC, 4'h0});
        queue_beat(MODE_LOAD, 4'($urandom), 8'($urandom));
        repeat (4) queue_exec();

        // Hold reset, then release it.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || s_axis_tvalid || states_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
